// ===== sv/bppl_pkg.sv =====
// Package for the banded plane piece locator: sizes, codes and shared structs.
`default_nettype none
package bppl_pkg;

    // Table sizes
    localparam int MAX_BANDS  = 16;
    localparam int MAX_CUTS   = 16;

    // Field widths
    localparam int COORD_W    = 32;
    localparam int BAND_FW    = 5;
    localparam int SLOT_FW    = 4;
    localparam int REQ_W      = 2;
    localparam int BCOUNT_W   = 5;
    localparam int TOL_W      = 31;
    localparam int PIECE_W    = 9;
    localparam int CFG_IDX_W  = 2;

    // Derived storage sizes
    localparam int BB_DEPTH   = MAX_BANDS + 1;
    localparam int BB_AW      = $clog2(BB_DEPTH);
    localparam int BAND_IW    = $clog2(MAX_BANDS);
    localparam int SLOT_IW    = $clog2(MAX_CUTS);
    localparam int CT_DEPTH   = MAX_BANDS * MAX_CUTS;
    localparam int CT_AW      = BAND_IW + SLOT_IW;
    localparam int CNT_W      = $clog2(MAX_CUTS + 1);

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_BOUND  = 2'd0,
        REQ_CUT    = 2'd1,
        REQ_COUNT  = 2'd2,
        REQ_LOCATE = 2'd3
    } t_req;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_BEGIN    = 2'd0,
        CFG_X_END      = 2'd1,
        CFG_BAND_COUNT = 2'd2,
        CFG_TOLERANCE  = 2'd3
    } t_cfg_idx;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic [COORD_W-1:0]  x_begin;
        logic [COORD_W-1:0]  x_end;
        logic [BCOUNT_W-1:0] band_count;
        logic [TOL_W-1:0]    tolerance;
    } t_cfg;

    // Boundary memory ports
    typedef struct packed {
        logic               we;
        logic [BB_AW-1:0]   addr;
        logic [COORD_W-1:0] data;
    } t_bb_wr;

    typedef struct packed {
        logic             re;
        logic [BB_AW-1:0] addr;
    } t_bb_rd;

    // Cut memory ports
    typedef struct packed {
        logic               we;
        logic [CT_AW-1:0]   addr;
        logic [COORD_W-1:0] data;
    } t_ct_wr;

    typedef struct packed {
        logic             re;
        logic [CT_AW-1:0] addr;
    } t_ct_rd;

endpackage
`default_nettype wire

// ===== sv/bppl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bppl_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered while the read enable is high
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/bppl_seq.sv =====
// Sequencer: load writes, band walk, x slot walk, cut counts and result register.
`default_nettype none
module bppl_seq (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bppl_pkg::t_cfg               i_cfg,
    // request channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [bppl_pkg::REQ_W-1:0]   i_req_type,
    input  wire logic [bppl_pkg::BAND_FW-1:0] i_band,
    input  wire logic [bppl_pkg::SLOT_FW-1:0] i_slot,
    input  wire logic [bppl_pkg::COORD_W-1:0] i_value,
    input  wire logic [bppl_pkg::COORD_W-1:0] i_point_x,
    input  wire logic [bppl_pkg::COORD_W-1:0] i_point_y,
    // result channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [bppl_pkg::PIECE_W-1:0]      o_piece_id,
    output logic                              o_above_bands,
    // memories
    output bppl_pkg::t_bb_wr                  o_bb_wr,
    output bppl_pkg::t_bb_rd                  o_bb_rd,
    input  wire logic [bppl_pkg::COORD_W-1:0] i_bb_rdata,
    output bppl_pkg::t_ct_wr                  o_ct_wr,
    output bppl_pkg::t_ct_rd                  o_ct_rd,
    input  wire logic [bppl_pkg::COORD_W-1:0] i_ct_rdata
);
    import bppl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_Y_BASE,
        S_Y_WALK,
        S_X_START,
        S_X_WALK,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [COORD_W-1:0]   r_px, n_px;
    logic [COORD_W-1:0]   r_py, n_py;
    logic [COORD_W-1:0]   r_prev, n_prev;
    logic [BAND_IW-1:0]   r_k, n_k;
    logic [CNT_W-1:0]     r_n, n_n;
    logic [CNT_W-1:0]     r_j, n_j;
    logic [PIECE_W-1:0]   r_total, n_total;
    logic [PIECE_W-1:0]   r_res_piece, n_res_piece;
    logic                 r_res_above, n_res_above;
    logic                 r_out_valid, n_out_valid;
    logic [PIECE_W-1:0]   r_out_piece, n_out_piece;
    logic                 r_out_above, n_out_above;

    logic [CNT_W-1:0]     r_cnt [MAX_BANDS];
    logic                 cnt_we;
    logic [BAND_IW-1:0]   cnt_idx;
    logic [CNT_W-1:0]     cnt_val;
    logic [CNT_W-1:0]     cnt_rd;

    logic                 accept;
    logic                 band_ok;
    logic [BAND_IW-1:0]   last_k;
    logic signed [COORD_W:0] y_diff;
    logic signed [COORD_W:0] x_diff;
    logic signed [COORD_W:0] tol_ext;
    logic                 y_bottom;
    logic                 x_left;
    logic [COORD_W-1:0]   x_hi;
    logic                 y_hit;
    logic                 x_hit;
    logic                 out_free;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign band_ok    = (i_band != '0) && (i_band <= BAND_FW'(MAX_BANDS));
    assign cnt_rd     = r_cnt[r_k];

    // Index of the last band in use, band count clamped into range
    always_comb begin
        priority if (i_cfg.band_count == '0) begin
            last_k = '0;
        end else if (i_cfg.band_count > BCOUNT_W'(MAX_BANDS)) begin
            last_k = BAND_IW'(MAX_BANDS - 1);
        end else begin
            last_k = BAND_IW'(i_cfg.band_count - BCOUNT_W'(1));
        end
    end

    // Edge tolerance tests, exact in one extra bit
    assign tol_ext  = $signed({{(COORD_W + 1 - TOL_W){1'b0}}, i_cfg.tolerance});
    assign y_diff   = $signed({r_py[COORD_W-1], r_py})
                    - $signed({i_bb_rdata[COORD_W-1], i_bb_rdata});
    assign x_diff   = $signed({r_px[COORD_W-1], r_px})
                    - $signed({i_cfg.x_begin[COORD_W-1], i_cfg.x_begin});
    assign y_bottom = (y_diff <= tol_ext);
    assign x_left   = (x_diff < tol_ext);

    // Interval tests against the previous bound and the word just read
    assign y_hit = ($signed(r_py) > $signed(r_prev)) && ($signed(r_py) <= $signed(i_bb_rdata));
    assign x_hi  = (r_j == r_n) ? i_cfg.x_end : i_ct_rdata;
    assign x_hit = ($signed(r_px) > $signed(r_prev)) && ($signed(r_px) <= $signed(x_hi));

    // Cut count value, saturated
    always_comb begin
        priority if (i_value[COORD_W-1]) begin
            cnt_val = '0;
        end else if ($signed(i_value) > $signed(COORD_W'(MAX_CUTS))) begin
            cnt_val = CNT_W'(MAX_CUTS);
        end else begin
            cnt_val = i_value[CNT_W-1:0];
        end
    end

    assign cnt_idx = BAND_IW'(i_band - BAND_FW'(1));

    // Next state and memory requests
    always_comb begin
        n_state     = r_state;
        n_px        = r_px;
        n_py        = r_py;
        n_prev      = r_prev;
        n_k         = r_k;
        n_n         = r_n;
        n_j         = r_j;
        n_total     = r_total;
        n_res_piece = r_res_piece;
        n_res_above = r_res_above;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_piece = r_out_piece;
        n_out_above = r_out_above;
        o_bb_wr     = '0;
        o_bb_rd     = '0;
        o_ct_wr     = '0;
        o_ct_rd     = '0;
        cnt_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_req'(i_req_type))
                        REQ_BOUND: begin
                            if (i_band <= BAND_FW'(MAX_BANDS)) begin
                                o_bb_wr = '{we: 1'b1, addr: BB_AW'(i_band), data: i_value};
                            end
                        end
                        REQ_CUT: begin
                            if (band_ok) begin
                                o_ct_wr = '{we: 1'b1, addr: {cnt_idx, SLOT_IW'(i_slot)},
                                            data: i_value};
                            end
                        end
                        REQ_COUNT: begin
                            cnt_we = band_ok;
                        end
                        REQ_LOCATE: begin
                            o_bb_rd = '{re: 1'b1, addr: '0};
                            n_px    = i_point_x;
                            n_py    = i_point_y;
                            n_k     = '0;
                            n_total = '0;
                            n_state = S_Y_BASE;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Lowest boundary: bottom edge with tolerance
            S_Y_BASE: begin
                if (y_bottom) begin
                    n_n     = cnt_rd;
                    n_state = S_X_START;
                end else begin
                    n_prev  = i_bb_rdata;
                    o_bb_rd = '{re: 1'b1, addr: BB_AW'(1)};
                    n_state = S_Y_WALK;
                end
            end

            // One band per cycle, piece counts summed on the way up
            S_Y_WALK: begin
                priority if (y_hit) begin
                    n_n     = cnt_rd;
                    n_state = S_X_START;
                end else if (r_k == last_k) begin
                    n_res_piece = '0;
                    n_res_above = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_total = r_total + PIECE_W'(cnt_rd) + PIECE_W'(1);
                    n_prev  = i_bb_rdata;
                    n_k     = r_k + BAND_IW'(1);
                    o_bb_rd = '{re: 1'b1, addr: BB_AW'(r_k) + BB_AW'(2)};
                end
            end

            // Left edge or empty band gives slot zero
            S_X_START: begin
                if (x_left || (r_n == '0)) begin
                    n_res_piece = r_total;
                    n_res_above = 1'b0;
                    n_state     = S_DONE;
                end else begin
                    o_ct_rd = '{re: 1'b1, addr: {r_k, SLOT_IW'(0)}};
                    n_prev  = i_cfg.x_begin;
                    n_j     = '0;
                    n_state = S_X_WALK;
                end
            end

            // One slot per cycle; last slot closes at x_end
            S_X_WALK: begin
                priority if (x_hit) begin
                    n_res_piece = r_total + PIECE_W'(r_j);
                    n_res_above = 1'b0;
                    n_state     = S_DONE;
                end else if (r_j == r_n) begin
                    n_res_piece = r_total;
                    n_res_above = 1'b0;
                    n_state     = S_DONE;
                end else begin
                    n_prev  = i_ct_rdata;
                    n_j     = r_j + CNT_W'(1);
                    o_ct_rd = '{re: 1'b1, addr: {r_k, SLOT_IW'(r_j + CNT_W'(1))}};
                end
            end

            // Hand the result to the output register once it is free
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_piece = r_res_piece;
                    n_out_above = r_res_above;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_px        <= n_px;
        r_py        <= n_py;
        r_prev      <= n_prev;
        r_k         <= n_k;
        r_n         <= n_n;
        r_j         <= n_j;
        r_total     <= n_total;
        r_res_piece <= n_res_piece;
        r_res_above <= n_res_above;
        r_out_piece <= n_out_piece;
        r_out_above <= n_out_above;
    end

    // Cut counts per band, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < MAX_BANDS; b++) begin
                r_cnt[b] <= '0;
            end
        end else if (cnt_we) begin
            r_cnt[cnt_idx] <= cnt_val;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_piece_id    = r_out_piece;
    assign o_above_bands = r_out_above;

endmodule
`default_nettype wire

// ===== sv/banded_plane_piece_locator_unit.sv =====
// Locate request: the band walk, then the slot walk, from accept to result beat,
// one memory word per cycle on each read port.
// One locate is in flight at a time; load requests are taken back to back from idle.
// The next request is taken while a result beat still waits on the output.
// Reset (synchronous, active low) sets x_begin/x_end to 0, band count and tolerance
// to 1 and clears the cut counts; boundary and cut memories are not initialised.
`default_nettype none
module banded_plane_piece_locator_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [bppl_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [bppl_pkg::BAND_FW-1:0]   i_band,
    input  wire logic [bppl_pkg::SLOT_FW-1:0]   i_slot,
    input  wire logic [bppl_pkg::COORD_W-1:0]   i_value,
    input  wire logic [bppl_pkg::COORD_W-1:0]   i_point_x,
    input  wire logic [bppl_pkg::COORD_W-1:0]   i_point_y,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [bppl_pkg::PIECE_W-1:0]        o_piece_id,
    output logic                                o_above_bands,
    // configuration channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bppl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bppl_pkg::COORD_W-1:0]   i_cfg_data
);
    import bppl_pkg::*;

    t_cfg               r_cfg;
    t_bb_wr             bb_wr;
    t_bb_rd             bb_rd;
    t_ct_wr             ct_wr;
    t_ct_rd             ct_rd;
    logic [COORD_W-1:0] bb_rdata;
    logic [COORD_W-1:0] ct_rdata;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_begin    <= '0;
            r_cfg.x_end      <= '0;
            r_cfg.band_count <= BCOUNT_W'(1);
            r_cfg.tolerance  <= TOL_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_X_BEGIN:    r_cfg.x_begin    <= i_cfg_data;
                CFG_X_END:      r_cfg.x_end      <= i_cfg_data;
                CFG_BAND_COUNT: r_cfg.band_count <= i_cfg_data[BCOUNT_W-1:0];
                CFG_TOLERANCE:  r_cfg.tolerance  <= i_cfg_data[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Band boundary memory
    bppl_ram #(
        .DEPTH (BB_DEPTH),
        .WIDTH (COORD_W)
    ) u_bb_ram (
        .i_clk   (i_clk),
        .i_we    (bb_wr.we),
        .i_waddr (bb_wr.addr),
        .i_wdata (bb_wr.data),
        .i_re    (bb_rd.re),
        .i_raddr (bb_rd.addr),
        .o_rdata (bb_rdata)
    );

    // Per-band x cut memory
    bppl_ram #(
        .DEPTH (CT_DEPTH),
        .WIDTH (COORD_W)
    ) u_ct_ram (
        .i_clk   (i_clk),
        .i_we    (ct_wr.we),
        .i_waddr (ct_wr.addr),
        .i_wdata (ct_wr.data),
        .i_re    (ct_rd.re),
        .i_raddr (ct_rd.addr),
        .o_rdata (ct_rdata)
    );

    // Sequencer
    bppl_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_band        (i_band),
        .i_slot        (i_slot),
        .i_value       (i_value),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_piece_id    (o_piece_id),
        .o_above_bands (o_above_bands),
        .o_bb_wr       (bb_wr),
        .o_bb_rd       (bb_rd),
        .i_bb_rdata    (bb_rdata),
        .o_ct_wr       (ct_wr),
        .o_ct_rd       (ct_rd),
        .i_ct_rdata    (ct_rdata)
    );

    // Loads and walks never touch a memory in the same cycle
    a_bb_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(bb_wr.we && bb_rd.re))
        else $error("boundary memory written and read in one cycle");

    a_ct_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ct_wr.we && ct_rd.re))
        else $error("cut memory written and read in one cycle");

    // A point above every band always reports piece zero
    a_above_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_above_bands) |-> (o_piece_id == '0))
        else $error("above-bands result with non-zero piece");

    // A locate beat holds off further requests while it walks
    a_locate_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_req_type == REQ_LOCATE)) |=> o_in_stall)
        else $error("request taken during a locate walk");

endmodule
`default_nettype wire

// ===== sim/banded_plane_piece_locator_unit_tb.sv =====
// Testbench for the banded plane piece locator: table loads, point locates and checks.
`default_nettype none
module banded_plane_piece_locator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bppl_pkg::*;

    localparam longint COORD_MIN     = -64'sd2147483648;
    localparam longint COORD_MAX     = 64'sd2147483647;
    localparam int     SETTLE_CYCLES = 48;

    typedef struct packed {
        logic [PIECE_W-1:0] piece;
        logic               above;
    } t_piece_res;

    // DUT stimulus, all known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic [REQ_W-1:0]     i_req_type    = '0;
    logic [BAND_FW-1:0]   i_band        = '0;
    logic [SLOT_FW-1:0]   i_slot        = '0;
    logic [COORD_W-1:0]   i_value       = '0;
    logic [COORD_W-1:0]   i_point_x     = '0;
    logic [COORD_W-1:0]   i_point_y     = '0;
    logic                 i_out_stall   = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [COORD_W-1:0]   i_cfg_data    = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [PIECE_W-1:0]   o_piece_id;
    logic                 o_above_bands;
    logic                 o_cfg_ready;

    // Shadow of the locator's tables and registers
    logic signed [COORD_W-1:0] bound_mem [0:MAX_BANDS];
    logic signed [COORD_W-1:0] cut_mem   [0:MAX_BANDS*MAX_CUTS-1];
    logic [BCOUNT_W-1:0]       count_mem [0:MAX_BANDS-1];
    logic signed [COORD_W-1:0] cfg_x_begin;
    logic signed [COORD_W-1:0] cfg_x_end;
    logic [BCOUNT_W-1:0]       cfg_band_count;
    logic [TOL_W-1:0]          cfg_tol;

    t_piece_res piece_queue [$];
    int         miss_count  = 0;
    bit         steady_flow = 1'b0;
    int         hold_left   = 0;

    banded_plane_piece_locator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_band        (i_band),
        .i_slot        (i_slot),
        .i_value       (i_value),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_piece_id    (o_piece_id),
        .o_above_bands (o_above_bands),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Idle length: mostly the shortest, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 1;
        if (r < 92) return $urandom_range(2, 4);
        if (r < 98) return $urandom_range(5, 12);
        return $urandom_range(20, 60);
    endfunction

    // exact a - b <= t, or < t when strict
    function automatic bit diff_within(longint a, longint b, longint t, bit strict);
        if (a <= b) return strict ? (t > 0 || a < b) : 1'b1;
        return strict ? ((a - b) < t) : ((a - b) <= t);
    endfunction

    function automatic int bands_in_use();
        if (cfg_band_count < 1) return 1;
        if (cfg_band_count > MAX_BANDS) return MAX_BANDS;
        return int'(cfg_band_count);
    endfunction

    // Band walk, slot walk and prefix sum of the lower bands' pieces
    function automatic t_piece_res locate_piece(logic signed [COORD_W-1:0] px,
                                                logic signed [COORD_W-1:0] py);
        t_piece_res res;
        int         nb, yid, xid, n, total, base;
        bit         hit;
        longint     lo, hi, x, y;
        x     = px;
        y     = py;
        nb    = bands_in_use();
        yid   = 0;
        xid   = 0;
        total = 0;
        if (diff_within(y, bound_mem[0], longint'(cfg_tol), 1'b0)) begin
            yid = 1;
        end else begin
            for (int i = 1; i <= nb; i++) begin
                if (yid == 0 && y > bound_mem[i-1] && y <= bound_mem[i]) yid = i;
            end
        end
        if (yid == 0) begin
            res.piece = '0;
            res.above = 1'b1;
            return res;
        end
        n    = count_mem[yid-1];
        base = (yid - 1) * MAX_CUTS;
        hit  = 1'b0;
        if (!diff_within(x, cfg_x_begin, longint'(cfg_tol), 1'b1) && n > 0) begin
            for (int i = 0; i <= n; i++) begin
                lo = (i == 0) ? longint'(cfg_x_begin) : longint'(cut_mem[base + i - 1]);
                hi = (i == n) ? longint'(cfg_x_end) : longint'(cut_mem[base + i]);
                if (!hit && x > lo && x <= hi) begin
                    xid = i;
                    hit = 1'b1;
                end
            end
        end
        for (int i = 1; i < yid; i++) total += int'(count_mem[i-1]) + 1;
        total += xid;
        res.piece = PIECE_W'(total);
        res.above = 1'b0;
        return res;
    endfunction

    // Send one request beat, then fold it into the shadow state
    task automatic send_req(t_req req, logic [BAND_FW-1:0] band, logic [SLOT_FW-1:0] slot,
                            logic [COORD_W-1:0] value, logic [COORD_W-1:0] px,
                            logic [COORD_W-1:0] py);
        int cnt;
        if (!steady_flow && $urandom_range(0, 99) >= 55) begin
            i_in_valid <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_band     <= band;
        i_slot     <= slot;
        i_value    <= value;
        i_point_x  <= px;
        i_point_y  <= py;
        do @(posedge i_clk); while (o_in_stall);
        case (req)
            REQ_BOUND: begin
                if (band <= MAX_BANDS) bound_mem[band] = value;
            end
            REQ_CUT: begin
                if (band >= 1 && band <= MAX_BANDS)
                    cut_mem[(int'(band) - 1) * MAX_CUTS + int'(slot)] = value;
            end
            REQ_COUNT: begin
                if (band >= 1 && band <= MAX_BANDS) begin
                    if ($signed(value) < 0) cnt = 0;
                    else if ($signed(value) > MAX_CUTS) cnt = MAX_CUTS;
                    else cnt = int'(value);
                    count_mem[band - 1] = BCOUNT_W'(cnt);
                end
            end
            default: begin
                piece_queue.insert(piece_queue.size(), locate_piece(px, py));
            end
        endcase
    endtask

    task automatic send_load(t_req req, logic [BAND_FW-1:0] band, logic [SLOT_FW-1:0] slot,
                             logic [COORD_W-1:0] value);
        send_req(req, band, slot, value, $urandom, $urandom);
    endtask

    task automatic send_locate(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
        send_req(REQ_LOCATE, BAND_FW'($urandom), SLOT_FW'($urandom), $urandom, px, py);
    endtask

    // Register write, only issued while the block is idle
    task automatic write_reg(t_cfg_idx idx, logic [COORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_X_BEGIN:    cfg_x_begin    = data;
            CFG_X_END:      cfg_x_end      = data;
            CFG_BAND_COUNT: cfg_band_count = data[BCOUNT_W-1:0];
            default:        cfg_tol        = data[TOL_W-1:0];
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering, wait for every pending piece, then let the pipe go quiet
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (piece_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Start picked at random such that n steps of at most step stay in range
    function automatic longint span_start(longint step, int n);
        longint room;
        room = 64'sd4294967295 - longint'(n) * step;
        return COORD_MIN + longint'($urandom_range(0, 32'(room)));
    endfunction

    function automatic longint pick_step();
        case ($urandom_range(0, 2))
            0:       return 64'sd4;
            1:       return 64'sd65536;
            default: return 64'sd134217728;
        endcase
    endfunction

    // Point close to an anchor, often exactly on a tolerance edge
    function automatic logic [COORD_W-1:0] near_point(longint anchor);
        longint off;
        case ($urandom_range(0, 9))
            0:       off = 0;
            1:       off = 1;
            2:       off = -1;
            3:       off = longint'(cfg_tol);
            4:       off = -longint'(cfg_tol);
            5:       off = longint'(cfg_tol) + 1;
            6:       off = longint'(cfg_tol) - 1;
            7:       off = longint'($urandom_range(0, 255)) - 128;
            default: off = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
        return COORD_W'(anchor + off);
    endfunction

    // Sorted bounds, sorted cuts per band and a cut count for each band in use
    task automatic load_layout(int nb, longint y_step, longint x_step, longint x_origin,
                               bit all_cuts);
        longint             y, c;
        int                 n, r;
        logic [COORD_W-1:0] cv;
        y = span_start(y_step, MAX_BANDS + 1);
        for (int k = 0; k <= MAX_BANDS; k++) begin
            send_load(REQ_BOUND, BAND_FW'(k), SLOT_FW'($urandom), COORD_W'(y));
            y += longint'($urandom_range(0, 32'(y_step)));
        end
        for (int b = 1; b <= nb; b++) begin
            r = $urandom_range(0, 9);
            n = (r == 0) ? 0 : ((r == 1) ? MAX_CUTS : $urandom_range(1, MAX_CUTS - 1));
            c = x_origin;
            for (int s = 0; s < MAX_CUTS; s++) begin
                c += longint'($urandom_range(0, 32'(x_step)));
                // cuts past the count are never walked, so they keep older values
                if (all_cuts || s < n) begin
                    // the odd stray cut leaves the band unsorted
                    cv = ($urandom_range(0, 39) == 0) ? $urandom : COORD_W'(c);
                    send_load(REQ_CUT, BAND_FW'(b), SLOT_FW'(s), cv);
                end
            end
            cv = COORD_W'(n);
            if (n == MAX_CUTS && $urandom_range(0, 1)) cv = $urandom_range(16, 32'h7FFF_FFFF);
            if (n == 0 && $urandom_range(0, 1)) cv = 32'h8000_0000 | $urandom;
            send_load(REQ_COUNT, BAND_FW'(b), SLOT_FW'($urandom), cv);
        end
    endtask

    task automatic random_locate();
        logic [COORD_W-1:0] px, py;
        int                 b, r, n;
        if ($urandom_range(0, 19) == 0) py = $urandom;
        else py = near_point(bound_mem[$urandom_range(0, bands_in_use())]);
        b = $urandom_range(0, bands_in_use() - 1);
        n = int'(count_mem[b]);
        r = $urandom_range(0, 19);
        if (r == 0) px = $urandom;
        else if (r < 3) px = near_point(cfg_x_begin);
        else if (r < 5) px = near_point(cfg_x_end);
        else px = near_point(cut_mem[b * MAX_CUTS +
                                     $urandom_range(0, (n > 0) ? n - 1 : MAX_CUTS - 1)]);
        send_locate(px, py);
    endtask

    // Every boundary and cut entry gets written before the first locate
    task automatic test_fill_tables();
        load_layout(MAX_BANDS, 64'sd65536, 64'sd65536, span_start(64'sd65536, MAX_CUTS + 1),
                    1'b1);
    endtask

    // Locates with the register values left by reset
    task automatic test_reset_state();
        send_locate(32'd0, 32'd0);
        send_locate(32'd1, 32'd1);
        repeat (4) random_locate();
    endtask

    // Small hand-built plane: edges, tolerances, empty band, count saturation, bad indexes
    task automatic test_edges();
        settle_block();
        write_reg(CFG_X_BEGIN, -1000);
        write_reg(CFG_X_END, 1000);
        write_reg(CFG_BAND_COUNT, 3);
        write_reg(CFG_TOLERANCE, 4);
        send_load(REQ_BOUND, 0, 0, -100);
        send_load(REQ_BOUND, 1, 0, 0);
        send_load(REQ_BOUND, 2, 0, 100);
        send_load(REQ_BOUND, 3, 0, 200);
        send_load(REQ_CUT, 1, 0, -500);
        send_load(REQ_CUT, 1, 1, 0);
        send_load(REQ_CUT, 1, 2, 500);
        send_load(REQ_COUNT, 1, 0, 3);
        send_load(REQ_COUNT, 2, 0, 0);
        send_load(REQ_CUT, 3, 0, -10);
        send_load(REQ_CUT, 3, 1, 10);
        send_load(REQ_COUNT, 3, 0, 2);
        // below the plane, and on the bottom tolerance edge
        send_locate(1, 32'h8000_0000);
        send_locate(1, -96);
        // top of band one inclusive, last slot
        send_locate(600, 0);
        // left tolerance edge strictly inside, then band three on a cut and at x_end
        send_locate(-997, 150);
        send_locate(10, 200);
        send_locate(1000, 200);
        // beyond the right edge, band with no cuts, far left
        send_locate(1001, 150);
        send_locate(32'h7FFF_FFFF, 50);
        send_locate(32'h8000_0000, 0);
        // above every band
        send_locate(5, 201);
        send_locate(5, 32'h7FFF_FFFF);
        // cut count saturation both ways
        send_load(REQ_COUNT, 2, 0, -7);
        send_load(REQ_COUNT, 3, 0, 1000);
        send_locate(5, 150);
        // out-of-range indexes must leave the tables alone
        send_load(REQ_BOUND, 17, 0, 32'h7FFF_FFFF);
        send_load(REQ_CUT, 0, 3, 32'h7FFF_FFFF);
        send_load(REQ_COUNT, 0, 0, 5);
        send_load(REQ_COUNT, 31, 0, 5);
        send_locate(600, 0);
    endtask

    // Band count of zero, at the table size and above it
    task automatic test_band_count_limits();
        logic [BCOUNT_W-1:0] trial [4] = '{5'd0, 5'd31, 5'd17, 5'd16};
        for (int k = 0; k < 4; k++) begin
            settle_block();
            write_reg(CFG_BAND_COUNT, {27'($urandom), trial[k]});
            repeat (10) random_locate();
        end
    endtask

    // Long receiver hold-off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        settle_block();
        steady_flow = 1'b1;
        hold_left   = 400;
        repeat (30) random_locate();
        steady_flow = 1'b0;
        settle_block();
    endtask

    // Phases of random layouts and settings, extremes first
    task automatic test_random_phases();
        logic [BCOUNT_W-1:0] bc;
        logic [TOL_W-1:0]    tol;
        longint              y_step, x_step, x_lo, x_hi;
        for (int p = 0; p < 6; p++) begin
            settle_block();
            y_step = pick_step();
            x_step = (p == 3) ? 64'sd134217728 : pick_step();
            case (p)
                0:       bc = 5'd16;
                1:       bc = 5'd0;
                2:       bc = 5'd31;
                default: bc = BCOUNT_W'($urandom_range(1, MAX_BANDS));
            endcase
            case (p)
                0:       tol = '0;
                1:       tol = '1;
                2:       tol = 31'd1;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       tol = TOL_W'($urandom_range(0, 8));
                        1:       tol = TOL_W'($urandom_range(0, 32'(x_step)));
                        2:       tol = TOL_W'($urandom);
                        default: tol = '0;
                    endcase
                end
            endcase
            x_lo = (p == 3) ? COORD_MIN : span_start(x_step, MAX_CUTS + 1);
            x_hi = (p == 3) ? COORD_MAX : x_lo + longint'(MAX_CUTS + 1) * x_step;
            // one phase runs with the plane edges swapped
            write_reg(CFG_X_BEGIN, COORD_W'((p == 4) ? x_hi : x_lo));
            write_reg(CFG_X_END, COORD_W'((p == 4) ? x_lo : x_hi));
            write_reg(CFG_BAND_COUNT, {27'($urandom), bc});
            write_reg(CFG_TOLERANCE, {1'($urandom), tol});
            load_layout(bands_in_use(), y_step, x_step, x_lo, 1'b0);
            steady_flow = (p == 5);
            for (int i = 0; i < 50; i++) begin
                // stray loads, bad indexes among them
                if ($urandom_range(0, 99) < 8)
                    send_load(t_req'($urandom_range(0, 2)), BAND_FW'($urandom_range(0, 31)),
                              SLOT_FW'($urandom), $urandom);
                random_locate();
            end
            steady_flow = 1'b0;
        end
    endtask

    // Result side stall: random runs, plus a counted hold-off on request
    initial begin : out_stall_gen
        int run_left;
        run_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (steady_flow) begin
                i_out_stall <= 1'b0;
                run_left = 0;
            end else if (run_left > 0) begin
                i_out_stall <= 1'b1;
                run_left--;
            end else if ($urandom_range(0, 99) < 25) begin
                i_out_stall <= 1'b1;
                run_left = idle_len() - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare each result beat with the oldest pending piece
    always @(posedge i_clk) begin : piece_checker
        t_piece_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (piece_queue.size() == 0) begin
                miss_count++;
                if (miss_count <= 10)
                    $display("unexpected result beat: piece_id %0d above_bands %0b",
                             o_piece_id, o_above_bands);
            end else begin
                want = piece_queue.pop_front();
                if (o_piece_id !== want.piece || o_above_bands !== want.above) begin
                    miss_count++;
                    if (miss_count <= 10)
                        $display("mismatch: piece_id exp %0d got %0d, above_bands exp %0b got %0b",
                                 want.piece, o_piece_id, want.above, o_above_bands);
                end
            end
        end
    end

    // Guard against a hung run
    initial begin : watchdog
        #(30_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : main_seq
        cfg_x_begin    = '0;
        cfg_x_end      = '0;
        cfg_band_count = 5'd1;
        cfg_tol        = 31'd1;
        for (int b = 0; b < MAX_BANDS; b++) count_mem[b] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_tables();
        test_reset_state();
        test_edges();
        test_band_count_limits();
        test_backpressure();
        test_random_phases();
        settle_block();
        if (miss_count == 0 && piece_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
sv/bppl_pkg.sv
sv/bppl_ram.sv
sv/bppl_seq.sv
sv/banded_plane_piece_locator_unit.sv
sim/banded_plane_piece_locator_unit_tb.sv
